// File: hdl/tih_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tih_pkg;

    localparam int BUCKETS = 256;
    localparam int ENTRIES = 1024;

    localparam int ID_W   = 10;
    localparam int LINK_W = $clog2(ENTRIES + 1);
    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int CFG_W  = 9;
    localparam int DCNT_W = 5;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] WORD_MASK = 32'hFFFFFFFF;

    localparam logic [1:0] KIND_ARRAY  = 2'd0;
    localparam logic [1:0] KIND_VECTOR = 2'd1;
    localparam logic [1:0] KIND_MODULE = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_HIT  = 2'd1;
    localparam logic [1:0] RES_NEW  = 2'd2;
    localparam logic [1:0] RES_FULL = 2'd3;

    localparam logic [1:0] WORD_KIND = 2'd0;
    localparam logic [1:0] WORD_LO   = 2'd1;
    localparam logic [1:0] WORD_HI   = 2'd2;
    localparam logic [1:0] WORD_AUX  = 2'd3;

    typedef struct packed {
        logic       load;
        logic       hash_step;
        logic       div_start;
        logic       div_step;
        logic       head_rd;
        logic       head_cap;
        logic       ent_rd;
        logic       ent_chk;
        logic       insert;
        logic       out_load;
        logic [1:0] res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic req_nop;
        logic hash_last;
        logic div_last;
        logic link_null;
        logic match;
        logic full;
        logic out_busy;
    } ctrl_sts_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [63:0]       elem;
        logic [31:0]       aux;
        logic [LINK_W-1:0] next;
    } entry_t;

endpackage
`default_nettype wire

// File: hdl/tih_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tih_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] element_id;
    logic [31:0] array_length;
    logic [31:0] module_index;

    modport source (output valid, cmd, element_id, array_length, module_index, input ready);
    modport sink   (input valid, cmd, element_id, array_length, module_index, output ready);
endinterface

interface tih_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] type_id;
    logic       found;
    logic       status;

    modport source (output valid, type_id, found, status, input ready);
    modport sink   (input valid, type_id, found, status, output ready);
endinterface
`default_nettype wire

// File: hdl/tih_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tih_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire tih_pkg::ctrl_sts_t  sts,
    output tih_pkg::ctrl_cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_NOP   = 4'd1;
    localparam logic [3:0] ST_HASH  = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_HEAD  = 4'd4;
    localparam logic [3:0] ST_HEADW = 4'd5;
    localparam logic [3:0] ST_WALK  = 4'd6;
    localparam logic [3:0] ST_ENTW  = 4'd7;
    localparam logic [3:0] ST_MISS  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.req_nop ? ST_NOP : ST_HASH;
                end
            end
            ST_NOP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res_sel  = tih_pkg::RES_NONE;
                    state_next   = ST_IDLE;
                end
            end
            ST_HASH:
            begin
                cmd.hash_step = 1'b1;
                if (sts.hash_last)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = ST_HEADW;
            end
            ST_HEADW:
            begin
                cmd.head_cap = 1'b1;
                state_next   = ST_WALK;
            end
            ST_WALK:
            begin
                if (sts.link_null)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = ST_ENTW;
                end
            end
            ST_ENTW:
            begin
                if (sts.match)
                begin
                    if (!sts.out_busy)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.res_sel  = tih_pkg::RES_HIT;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.ent_chk = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_MISS:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.full)
                    begin
                        cmd.res_sel = tih_pkg::RES_FULL;
                    end
                    else
                    begin
                        cmd.insert  = 1'b1;
                        cmd.res_sel = tih_pkg::RES_NEW;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/tih_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module tih_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [tih_pkg::CFG_W-1:0]  cfg_wdata,
    tih_req_if.sink                         req,
    tih_rsp_if.source                       rsp,
    input  wire tih_pkg::ctrl_cmd_t         cmd,
    output tih_pkg::ctrl_sts_t              sts
);

    logic [tih_pkg::CFG_W-1:0]  bcount_reg;
    logic [tih_pkg::CFG_W-1:0]  divisor;

    logic [1:0]                 kind_reg;
    logic [63:0]                elem_reg;
    logic [31:0]                aux_reg;
    logic [31:0]                hash_reg;
    logic [1:0]                 wcnt_reg;
    logic [tih_pkg::CFG_W-1:0]  rem_reg;
    logic [tih_pkg::DCNT_W-1:0] dcnt_reg;
    logic [tih_pkg::LINK_W-1:0] link_reg;
    logic [tih_pkg::LINK_W-1:0] head_link_reg;
    logic [tih_pkg::LINK_W-1:0] used_reg;

    logic [tih_pkg::LINK_W-1:0] head_mem [tih_pkg::BUCKETS];
    logic [tih_pkg::BUCKETS-1:0] head_valid_reg;
    logic [tih_pkg::LINK_W-1:0] head_q;
    logic                       head_vq;

    tih_pkg::entry_t            ent_mem [tih_pkg::ENTRIES];
    tih_pkg::entry_t            ent_q;

    logic                       out_valid_reg;
    logic [tih_pkg::ID_W-1:0]   out_id_reg;
    logic                       out_found_reg;
    logic                       out_status_reg;

    logic [31:0]                word;
    logic [tih_pkg::CFG_W:0]    rem_shift;
    logic [tih_pkg::BKT_W-1:0]  bucket;
    logic [tih_pkg::LINK_W-1:0] link_dec;

    assign bucket   = rem_reg[tih_pkg::BKT_W-1:0];
    assign link_dec = link_reg - tih_pkg::LINK_W'(1);

    always_comb
    begin
        if (bcount_reg == '0)
        begin
            divisor = tih_pkg::CFG_W'(1);
        end
        else if (bcount_reg > tih_pkg::CFG_W'(tih_pkg::BUCKETS))
        begin
            divisor = tih_pkg::CFG_W'(tih_pkg::BUCKETS);
        end
        else
        begin
            divisor = bcount_reg;
        end
    end

    always_comb
    begin
        case (wcnt_reg)
            tih_pkg::WORD_KIND: word = {30'd0, kind_reg};
            tih_pkg::WORD_LO:   word = elem_reg[31:0] & tih_pkg::WORD_MASK;
            tih_pkg::WORD_HI:   word = elem_reg[63:32];
            default:            word = aux_reg;
        endcase
    end

    assign rem_shift = {rem_reg, hash_reg[31]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= tih_pkg::CFG_W'(256);
        end
        else if (cfg_we)
        begin
            bcount_reg <= cfg_wdata;
        end
    end

    // Key capture, FNV-1a mixing one word per cycle, then a restoring
    // division of the hash that leaves the bucket index in rem_reg.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= req.cmd;
            hash_reg <= tih_pkg::FNV_BASIS;
            wcnt_reg <= tih_pkg::WORD_KIND;
            case (req.cmd)
                tih_pkg::KIND_ARRAY:
                begin
                    elem_reg <= req.element_id;
                    aux_reg  <= req.array_length;
                end
                tih_pkg::KIND_VECTOR:
                begin
                    elem_reg <= req.element_id;
                    aux_reg  <= '0;
                end
                default:
                begin
                    elem_reg <= '0;
                    aux_reg  <= req.module_index;
                end
            endcase
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= 32'((hash_reg ^ word) * tih_pkg::FNV_PRIME);
            // Module keys skip the element words.
            if (wcnt_reg == tih_pkg::WORD_KIND && kind_reg == tih_pkg::KIND_MODULE)
            begin
                wcnt_reg <= tih_pkg::WORD_AUX;
            end
            else
            begin
                wcnt_reg <= wcnt_reg + 2'd1;
            end
        end
        else if (cmd.div_step)
        begin
            hash_reg <= {hash_reg[30:0], 1'b0};
            if (rem_shift >= {1'b0, divisor})
            begin
                rem_reg <= tih_pkg::CFG_W'(rem_shift - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= rem_shift[tih_pkg::CFG_W-1:0];
            end
            dcnt_reg <= dcnt_reg + tih_pkg::DCNT_W'(1);
        end
        if (cmd.div_start)
        begin
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.head_cap)
        begin
            link_reg      <= head_vq ? head_q : '0;
            head_link_reg <= head_vq ? head_q : '0;
        end
        else if (cmd.ent_chk)
        begin
            link_reg <= ent_q.next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.head_rd)
        begin
            head_q <= head_mem[bucket];
        end
        if (cmd.insert)
        begin
            head_mem[bucket] <= used_reg + tih_pkg::LINK_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ent_rd)
        begin
            ent_q <= ent_mem[link_dec[tih_pkg::ID_W-1:0]];
        end
        if (cmd.insert)
        begin
            ent_mem[used_reg[tih_pkg::ID_W-1:0]] <= '{kind: kind_reg, elem: elem_reg,
                                                      aux: aux_reg, next: head_link_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= '0;
            head_vq        <= 1'b0;
            used_reg       <= '0;
        end
        else
        begin
            if (cmd.head_rd)
            begin
                head_vq <= head_valid_reg[bucket];
            end
            if (cmd.insert)
            begin
                head_valid_reg[bucket] <= 1'b1;
                used_reg               <= used_reg + tih_pkg::LINK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.res_sel)
                tih_pkg::RES_HIT:
                begin
                    out_id_reg     <= link_dec[tih_pkg::ID_W-1:0];
                    out_found_reg  <= 1'b1;
                    out_status_reg <= 1'b0;
                end
                tih_pkg::RES_NEW:
                begin
                    out_id_reg     <= used_reg[tih_pkg::ID_W-1:0];
                    out_found_reg  <= 1'b0;
                    out_status_reg <= 1'b0;
                end
                tih_pkg::RES_FULL:
                begin
                    out_id_reg     <= '0;
                    out_found_reg  <= 1'b0;
                    out_status_reg <= 1'b1;
                end
                default:
                begin
                    out_id_reg     <= '0;
                    out_found_reg  <= 1'b0;
                    out_status_reg <= 1'b0;
                end
            endcase
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.type_id = out_id_reg;
    assign rsp.found   = out_found_reg;
    assign rsp.status  = out_status_reg;

    assign sts.req_nop   = (req.cmd == tih_pkg::KIND_UNUSED);
    assign sts.hash_last = (wcnt_reg == tih_pkg::WORD_AUX);
    assign sts.div_last  = (dcnt_reg == '1);
    // A link past the fill count points at nothing that was ever written.
    assign sts.link_null = (link_reg == '0) || (link_reg > used_reg);
    assign sts.match     = (ent_q.kind == kind_reg) && (ent_q.elem == elem_reg) &&
                           (ent_q.aux == aux_reg);
    assign sts.full      = (used_reg == tih_pkg::LINK_W'(tih_pkg::ENTRIES));
    assign sts.out_busy  = out_valid_reg && !rsp.ready;

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (used_reg < tih_pkg::LINK_W'(tih_pkg::ENTRIES)))
        else $error("insert with a full entry pool");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> (used_reg == $past(used_reg) + tih_pkg::LINK_W'(1)))
        else $error("fill count did not advance on insert");

    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.head_rd |-> (rem_reg < divisor))
        else $error("bucket index not below the divisor");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp.ready))
        else $error("result loaded over an untaken result");

endmodule
`default_nettype wire

// File: hdl/type_interning_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Payload                                         Transfer
// cfg      in   cfg_wdata[8:0] bucket_count                     cfg_we high
// req      in   cmd, element_id, array_length, module_index     valid && ready
// rsp      out  type_id, found, status                          valid && ready
//
// A request runs FNV mixing over its key words (only kind and aux for module
// keys), a bit-serial remainder of the hash, a bucket head read, a fetch and
// compare for each chain entry visited, and a result step to finish.
// Reset clears all bucket heads at once through per-bucket valid flops.
// A stalled result holds in the output register; a new request is taken
// meanwhile and waits at its result step until the register frees.
module type_interning_hash_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [tih_pkg::CFG_W-1:0] cfg_wdata,
    tih_req_if.sink                        req,
    tih_rsp_if.source                      rsp
);

    tih_pkg::ctrl_cmd_t cmd;
    tih_pkg::ctrl_sts_t sts;

    tih_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tih_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
`default_nettype wire
